>>> hw/rtl/pbsd_pkg.sv
// pbsd_pkg: shared types, constants and helpers of the power button shutdown block
`timescale 1ns / 1ps

package pbsd_pkg;

   // field widths
   localparam int unsigned SpeedWidth     = 24;
   localparam int unsigned ThresholdWidth = 23;
   localparam int unsigned HoldWidth      = 16;
   localparam int unsigned SampleWidth    = 8;
   localparam int unsigned ModeCodeWidth  = 3;
   localparam int unsigned CsrIndexWidth  = 2;
   localparam int unsigned CsrDataWidth   = 23;

   typedef logic signed [SpeedWidth-1:0]     speed_type;
   typedef logic        [SpeedWidth-1:0]     magnitude_type;
   typedef logic        [ThresholdWidth-1:0] threshold_type;
   typedef logic        [HoldWidth-1:0]      hold_type;
   typedef logic        [SampleWidth-1:0]    sample_type;
   typedef logic        [ModeCodeWidth-1:0]  mode_code_type;
   typedef logic        [CsrIndexWidth-1:0]  csr_index_type;
   typedef logic        [CsrDataWidth-1:0]   csr_data_type;

   // register indexes
   localparam csr_index_type CSR_DEBOUNCE_SAMPLES = 2'd0;
   localparam csr_index_type CSR_NORMAL_HOLD      = 2'd1;
   localparam csr_index_type CSR_EMERGENCY_HOLD   = 2'd2;
   localparam csr_index_type CSR_SPEED_THRESHOLD  = 2'd3;

   // register reset values
   localparam sample_type    DEBOUNCE_SAMPLES_RST = 8'd2;
   localparam hold_type      NORMAL_HOLD_RST      = 16'd50;
   localparam hold_type      EMERGENCY_HOLD_RST   = 16'd300;
   localparam threshold_type SPEED_THRESHOLD_RST  = 23'd100;

   localparam hold_type HOLD_MAX = '1;

   // reported mode codes
   localparam mode_code_type MODE_CODE_IDLE      = 3'd0;
   localparam mode_code_type MODE_CODE_HOLDING   = 3'd1;
   localparam mode_code_type MODE_CODE_ARMED     = 3'd2;
   localparam mode_code_type MODE_CODE_FORCE     = 3'd3;
   localparam mode_code_type MODE_CODE_REQUESTED = 3'd4;

   // internal one-hot mode
   typedef enum logic [4:0] {
      MODE_IDLE      = 5'b00001,
      MODE_HOLDING   = 5'b00010,
      MODE_ARMED     = 5'b00100,
      MODE_FORCE     = 5'b01000,
      MODE_REQUESTED = 5'b10000
   } mode_type;

   // configuration as seen by the datapath
   typedef struct packed {
      sample_type    debounce_samples;
      hold_type      normal_hold_ticks;
      hold_type      emergency_hold_ticks;
      threshold_type speed_threshold;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic          keep_power;
      logic          buzzer_level;
      logic          short_beep;
      logic          debounced_press;
      mode_code_type mode_code;
   } result_type;

   // magnitude of a two's complement speed, up to 2^23
   function automatic magnitude_type speed_magnitude(input speed_type speed);
      magnitude_type raw_bits;
      raw_bits = magnitude_type'(speed);
      if (speed[SpeedWidth-1]) begin
         return magnitude_type'(~raw_bits + magnitude_type'(1));
      end
      return raw_bits;
   endfunction

   // reported code of a mode
   function automatic mode_code_type mode_code_of(input mode_type mode);
      case (mode)
         MODE_IDLE:      return MODE_CODE_IDLE;
         MODE_HOLDING:   return MODE_CODE_HOLDING;
         MODE_ARMED:     return MODE_CODE_ARMED;
         MODE_FORCE:     return MODE_CODE_FORCE;
         MODE_REQUESTED: return MODE_CODE_REQUESTED;
         default:        return MODE_CODE_IDLE;
      endcase
   endfunction

endpackage

>>> hw/rtl/pbsd_channels.sv
// pbsd_channels: valid/ready channel interfaces for tick items and result items
`timescale 1ns / 1ps

interface pbsd_req_if import pbsd_pkg::*;;
   logic      valid;
   logic      ready;
   logic      raw_level;
   speed_type motor_speed;

   modport source (output valid, output raw_level, output motor_speed, input ready);
   modport sink   (input valid, input raw_level, input motor_speed, output ready);
endinterface

interface pbsd_rsp_if import pbsd_pkg::*;;
   logic          valid;
   logic          ready;
   logic          keep_power;
   logic          buzzer_level;
   logic          short_beep;
   logic          debounced_press;
   mode_code_type mode_code;

   modport source (output valid, output keep_power, output buzzer_level, output short_beep,
                   output debounced_press, output mode_code, input ready);
   modport sink   (input valid, input keep_power, input buzzer_level, input short_beep,
                   input debounced_press, input mode_code, output ready);
endinterface

>>> hw/rtl/power_button_shutdown_fsm_core.sv
// power_button_shutdown_fsm_core: top level of the power button shutdown controller
//
//   channel  direction  carries
//   req      in         raw_level, motor_speed (one tick per item)
//   rsp      out        keep_power, buzzer_level, short_beep, debounced_press, mode_code
//   csr      in         write enable, register index, write data
//
// one item per cycle while rsp is not stalled; an item taken on req is valid on rsp once
// it has passed the input register, then debounce and mode logic into the result register
// reset is synchronous: mode idle, counters zero, registers at their defaults
// a stalled rsp holds the result register; req keeps taking an item while the input
// register is empty or moving on
`timescale 1ns / 1ps

module power_button_shutdown_fsm_core import pbsd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   pbsd_req_if.sink      req,
   pbsd_rsp_if.source    rsp,
   input  logic          csr_write_en,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_write_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       raw_ff;
   speed_type  speed_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       pressed;
   logic       step;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_samples     <= DEBOUNCE_SAMPLES_RST;
         cfg_ff.normal_hold_ticks    <= NORMAL_HOLD_RST;
         cfg_ff.emergency_hold_ticks <= EMERGENCY_HOLD_RST;
         cfg_ff.speed_threshold      <= SPEED_THRESHOLD_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEBOUNCE_SAMPLES: cfg_ff.debounce_samples <= csr_write_data[SampleWidth-1:0];
            CSR_NORMAL_HOLD:      cfg_ff.normal_hold_ticks <= csr_write_data[HoldWidth-1:0];
            CSR_EMERGENCY_HOLD:   cfg_ff.emergency_hold_ticks <= csr_write_data[HoldWidth-1:0];
            CSR_SPEED_THRESHOLD:  cfg_ff.speed_threshold <= csr_write_data;
            default:              cfg_ff <= cfg_ff;
         endcase
      end
   end

   // an item is worked on when the result register is free or being drained
   assign step      = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         raw_ff   <= req.raw_level;
         speed_ff <= req.motor_speed;
      end
   end

   pbsd_debounce u_debounce (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .raw_level        (raw_ff),
      .debounce_samples (cfg_ff.debounce_samples),
      .pressed          (pressed)
   );

   pbsd_mode_fsm u_mode_fsm (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .pressed     (pressed),
      .motor_speed (speed_ff),
      .cfg         (cfg_ff),
      .result      (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.keep_power      = out_ff.keep_power;
   assign rsp.buzzer_level    = out_ff.buzzer_level;
   assign rsp.short_beep      = out_ff.short_beep;
   assign rsp.debounced_press = out_ff.debounced_press;
   assign rsp.mode_code       = out_ff.mode_code;

endmodule

>>> hw/rtl/pbsd_debounce.sv
// pbsd_debounce: stability counter that turns the raw button level into a debounced level
`timescale 1ns / 1ps

module pbsd_debounce import pbsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       raw_level,
   input  sample_type debounce_samples,
   output logic       pressed
);

   logic       last_raw_ff, last_raw_in;
   sample_type stable_count_ff, stable_count_in;
   logic       debounced_ff, debounced_in;

   // count equal samples, restart on a change
   always_comb begin
      last_raw_in = raw_level;
      if (raw_level == last_raw_ff) begin
         if (stable_count_ff < debounce_samples) begin
            stable_count_in = stable_count_ff + sample_type'(1);
         end else begin
            stable_count_in = stable_count_ff;
         end
      end else begin
         stable_count_in = sample_type'(1);
      end
      debounced_in = (stable_count_in >= debounce_samples) ? raw_level : debounced_ff;
      pressed      = debounced_in;
   end

   // state moves on once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff     <= 1'b0;
         stable_count_ff <= '0;
         debounced_ff    <= 1'b0;
      end else if (step) begin
         last_raw_ff     <= last_raw_in;
         stable_count_ff <= stable_count_in;
         debounced_ff    <= debounced_in;
      end
   end

endmodule

>>> hw/rtl/pbsd_mode_fsm.sv
// pbsd_mode_fsm: hold counter and five-mode shutdown machine
`timescale 1ns / 1ps

module pbsd_mode_fsm import pbsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       pressed,
   input  speed_type  motor_speed,
   input  cfg_type    cfg,
   output result_type result
);

   mode_type      mode_ff, mode_in;
   hold_type      hold_ff, hold_in;
   logic          buzzer_ff, buzzer_in;
   logic          keep;
   logic          beep;
   hold_type      hold_inc;
   magnitude_type spd;
   magnitude_type limit;
   logic          slow;
   logic          fast;

   // speed compares against the threshold
   always_comb begin
      spd   = speed_magnitude(motor_speed);
      limit = magnitude_type'(cfg.speed_threshold);
      slow  = spd < limit;
      fast  = spd > limit;
      hold_inc = (hold_ff < HOLD_MAX) ? hold_ff + hold_type'(1) : hold_ff;
   end

   // next mode, hold count and buzzer
   always_comb begin
      mode_in   = mode_ff;
      hold_in   = hold_ff;
      buzzer_in = buzzer_ff;
      keep      = 1'b1;
      beep      = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (pressed) begin
               hold_in = hold_type'(1);
               mode_in = MODE_HOLDING;
            end else begin
               hold_in = '0;
            end
         end
         MODE_HOLDING: begin
            if (!pressed) begin
               hold_in   = '0;
               buzzer_in = 1'b0;
               mode_in   = MODE_IDLE;
            end else begin
               hold_in = hold_inc;
               if (hold_inc > cfg.normal_hold_ticks) begin
                  if (slow) begin
                     hold_in   = '0;
                     mode_in   = MODE_ARMED;
                     beep      = 1'b1;
                     buzzer_in = 1'b0;
                  end else if (hold_inc > cfg.emergency_hold_ticks) begin
                     buzzer_in = 1'b1;
                     hold_in   = '0;
                     mode_in   = MODE_FORCE;
                  end
               end
            end
         end
         MODE_ARMED: begin
            if (fast) begin
               hold_in   = '0;
               buzzer_in = 1'b0;
               mode_in   = MODE_IDLE;
            end else if (!pressed) begin
               buzzer_in = 1'b0;
               mode_in   = MODE_REQUESTED;
               keep      = 1'b0;
            end
         end
         MODE_FORCE: begin
            if (!pressed) begin
               buzzer_in = 1'b0;
               mode_in   = MODE_REQUESTED;
               keep      = 1'b0;
            end
         end
         MODE_REQUESTED: begin
            buzzer_in = 1'b0;
            keep      = 1'b0;
         end
         default: begin
            hold_in   = '0;
            buzzer_in = 1'b0;
            mode_in   = MODE_IDLE;
         end
      endcase

      result.keep_power      = keep;
      result.buzzer_level    = buzzer_in;
      result.short_beep      = beep;
      result.debounced_press = pressed;
      result.mode_code       = mode_code_of(mode_in);
   end

   // state moves on once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         hold_ff   <= '0;
         buzzer_ff <= 1'b0;
      end else if (step) begin
         mode_ff   <= mode_in;
         hold_ff   <= hold_in;
         buzzer_ff <= buzzer_in;
      end
   end

endmodule

>>> bench/pbsd_tick_checker.sv
// pbsd_tick_checker: predicts and checks the result items of the power button shutdown controller
`timescale 1ns / 1ps

module pbsd_tick_checker import pbsd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   pbsd_req_if           req,
   pbsd_rsp_if           rsp,
   input  logic          csr_write_en,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_write_data,
   output int            mismatch_count,
   output int            results_pending
);

   // settings as last written
   sample_type    debounce_setting;
   hold_type      normal_setting;
   hold_type      emergency_setting;
   threshold_type threshold_setting;

   // debounce and mode state
   logic          last_raw;
   sample_type    stable_run;
   logic          button_level;
   mode_code_type button_mode;
   hold_type      hold_ticks;
   logic          buzzer_on;

   // results owed by the block, oldest first
   result_type    owed_results[$];
   result_type    oldest_owed;
   int            fail_tally = 0;

   initial begin
      mismatch_count  = 0;
      results_pending = 0;
   end

   // one tick of debounce and mode logic, returns the result it owes
   function automatic result_type advance_button_fsm(input logic raw, input speed_type speed);
      result_type    outcome;
      magnitude_type magnitude;
      logic          slow;
      logic          fast;
      magnitude = speed[SpeedWidth-1] ? magnitude_type'(~speed) + magnitude_type'(1)
                                      : magnitude_type'(speed);
      slow = magnitude < magnitude_type'(threshold_setting);
      fast = magnitude > magnitude_type'(threshold_setting);
      outcome.keep_power = 1'b1;
      outcome.short_beep = 1'b0;

      // level follows raw only after enough equal samples
      if (raw == last_raw) begin
         if (stable_run < debounce_setting) stable_run = stable_run + sample_type'(1);
      end else begin
         last_raw   = raw;
         stable_run = sample_type'(1);
      end
      if (stable_run >= debounce_setting) button_level = raw;

      case (button_mode)
         MODE_CODE_IDLE: begin
            if (button_level) begin
               hold_ticks  = hold_type'(1);
               button_mode = MODE_CODE_HOLDING;
            end else begin
               hold_ticks = '0;
            end
         end
         MODE_CODE_HOLDING: begin
            if (!button_level) begin
               hold_ticks  = '0;
               buzzer_on   = 1'b0;
               button_mode = MODE_CODE_IDLE;
            end else begin
               if (hold_ticks != HOLD_MAX) hold_ticks = hold_ticks + hold_type'(1);
               // emergency limit only counts once the normal limit is passed
               if (hold_ticks > normal_setting) begin
                  if (slow) begin
                     hold_ticks         = '0;
                     button_mode        = MODE_CODE_ARMED;
                     outcome.short_beep = 1'b1;
                     buzzer_on          = 1'b0;
                  end else if (hold_ticks > emergency_setting) begin
                     buzzer_on   = 1'b1;
                     hold_ticks  = '0;
                     button_mode = MODE_CODE_FORCE;
                  end
               end
            end
         end
         MODE_CODE_ARMED: begin
            if (fast) begin
               hold_ticks  = '0;
               buzzer_on   = 1'b0;
               button_mode = MODE_CODE_IDLE;
            end else if (!button_level) begin
               buzzer_on          = 1'b0;
               button_mode        = MODE_CODE_REQUESTED;
               outcome.keep_power = 1'b0;
            end
         end
         MODE_CODE_FORCE: begin
            if (!button_level) begin
               buzzer_on          = 1'b0;
               button_mode        = MODE_CODE_REQUESTED;
               outcome.keep_power = 1'b0;
            end
         end
         MODE_CODE_REQUESTED: begin
            buzzer_on          = 1'b0;
            outcome.keep_power = 1'b0;
         end
         default: begin
            hold_ticks  = '0;
            buzzer_on   = 1'b0;
            button_mode = MODE_CODE_IDLE;
         end
      endcase

      outcome.buzzer_level    = buzzer_on;
      outcome.debounced_press = button_level;
      outcome.mode_code       = button_mode;
      return outcome;
   endfunction

   function automatic int field_mismatch(input string field, input logic [2:0] wanted,
                                         input logic [2:0] seen);
      if (seen === wanted) return 0;
      $error("%s: expected %0d, got %0d", field, wanted, seen);
      return 1;
   endfunction

   // watch both channels and the register port
   always @(posedge clock) begin
      if (reset) begin
         debounce_setting  = DEBOUNCE_SAMPLES_RST;
         normal_setting    = NORMAL_HOLD_RST;
         emergency_setting = EMERGENCY_HOLD_RST;
         threshold_setting = SPEED_THRESHOLD_RST;
         last_raw          = 1'b0;
         stable_run        = '0;
         button_level      = 1'b0;
         button_mode       = MODE_CODE_IDLE;
         hold_ticks        = '0;
         buzzer_on         = 1'b0;
         owed_results.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_DEBOUNCE_SAMPLES: debounce_setting  = sample_type'(csr_write_data);
               CSR_NORMAL_HOLD:      normal_setting    = hold_type'(csr_write_data);
               CSR_EMERGENCY_HOLD:   emergency_setting = hold_type'(csr_write_data);
               CSR_SPEED_THRESHOLD:  threshold_setting = threshold_type'(csr_write_data);
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (owed_results.size() == 0) begin
               $error("result item arrived with no tick waiting");
               fail_tally++;
            end else begin
               oldest_owed = owed_results.pop_front();
               fail_tally += field_mismatch("keep_power",
                                            mode_code_type'(oldest_owed.keep_power),
                                            mode_code_type'(rsp.keep_power));
               fail_tally += field_mismatch("buzzer_level",
                                            mode_code_type'(oldest_owed.buzzer_level),
                                            mode_code_type'(rsp.buzzer_level));
               fail_tally += field_mismatch("short_beep",
                                            mode_code_type'(oldest_owed.short_beep),
                                            mode_code_type'(rsp.short_beep));
               fail_tally += field_mismatch("debounced_press",
                                            mode_code_type'(oldest_owed.debounced_press),
                                            mode_code_type'(rsp.debounced_press));
               fail_tally += field_mismatch("mode_code", oldest_owed.mode_code,
                                            rsp.mode_code);
            end
         end
         if (req.valid && req.ready) begin
            owed_results.push_back(advance_button_fsm(req.raw_level, req.motor_speed));
         end
      end
      mismatch_count  <= fail_tally;
      results_pending <= owed_results.size();
   end

endmodule

>>> bench/tb_power_button_shutdown_fsm_core.sv
// tb_power_button_shutdown_fsm_core: stimulus and verdict for the power button shutdown controller
`timescale 1ns / 1ps

module tb_power_button_shutdown_fsm_core;
   import pbsd_pkg::*;

   localparam int unsigned SpeedSpan = 1 << (SpeedWidth - 1);
   localparam int unsigned ThresholdTop = (1 << ThresholdWidth) - 1;
   localparam int unsigned HoldTop = HOLD_MAX - 1;
   localparam speed_type SPEED_MAX = speed_type'(SpeedSpan - 1);
   localparam speed_type SPEED_MIN = speed_type'(SpeedSpan);

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_write_en;
   csr_index_type csr_index;
   csr_data_type  csr_write_data;

   pbsd_req_if req_ch ();
   pbsd_rsp_if rsp_ch ();

   int fail_total;
   int results_pending;

   // stimulus knobs and the settings the sequences are shaped for
   bit          req_gaps_on = 1'b1;
   bit          rsp_stalls_on = 1'b0;
   int          stall_left = 0;
   int unsigned ticks_sent = 0;
   int unsigned samples_now;
   int unsigned normal_now;
   int unsigned threshold_now;

   power_button_shutdown_fsm_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   pbsd_tick_checker u_tick_check (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .mismatch_count  (fail_total),
      .results_pending (results_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= gap_length() - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic int unsigned at_least_one(input int unsigned count);
      return (count == 0) ? 1 : count;
   endfunction

   // the full negative magnitude exists only with the sign bit set
   function automatic speed_type signed_speed(input int unsigned magnitude);
      if (magnitude == SpeedSpan || $urandom_range(0, 1) == 1) return -speed_type'(magnitude);
      return speed_type'(magnitude);
   endfunction

   function automatic speed_type slow_speed();
      int unsigned low_end;
      // nothing is below a zero threshold, fall back to the threshold itself
      if (threshold_now == 0) return speed_type'(0);
      low_end = (threshold_now > 4) ? threshold_now - 4 : 0;
      if ($urandom_range(0, 1) == 1) return signed_speed($urandom_range(low_end, threshold_now - 1));
      return signed_speed($urandom_range(0, threshold_now - 1));
   endfunction

   function automatic speed_type fast_speed();
      int unsigned low_end;
      int unsigned near_end;
      low_end  = threshold_now + 1;
      near_end = (low_end + 3 < SpeedSpan) ? low_end + 3 : SpeedSpan;
      if ($urandom_range(0, 1) == 1) return signed_speed($urandom_range(low_end, near_end));
      return signed_speed($urandom_range(low_end, SpeedSpan));
   endfunction

   function automatic speed_type level_speed();
      return signed_speed(threshold_now);
   endfunction

   // offer one tick item and hold it until taken
   task automatic send_tick(input logic raw, input speed_type speed);
      int gap;
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = gap_length();
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.raw_level   <= raw;
      req_ch.motor_speed <= speed;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ticks_sent++;
   endtask

   // stop sending and let every owed result come out
   task automatic wait_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_settings(input int unsigned samples, input int unsigned normal,
                                input int unsigned emergency, input int unsigned threshold);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_DEBOUNCE_SAMPLES;
      csr_write_data <= csr_data_type'(samples);
      @(posedge clock);
      csr_index      <= CSR_NORMAL_HOLD;
      csr_write_data <= csr_data_type'(normal);
      @(posedge clock);
      csr_index      <= CSR_EMERGENCY_HOLD;
      csr_write_data <= csr_data_type'(emergency);
      @(posedge clock);
      csr_index      <= CSR_SPEED_THRESHOLD;
      csr_write_data <= csr_data_type'(threshold);
      @(posedge clock);
      csr_write_en  <= 1'b0;
      samples_now   = samples;
      normal_now    = normal;
      threshold_now = threshold;
   endtask

   // fast ticks while released until the debounced level drops, back to idle
   task automatic release_button();
      repeat (at_least_one(samples_now) + $urandom_range(1, 3)) send_tick(1'b0, fast_speed());
   endtask

   // hold slow until armed, dwell, then cancel with a spinning motor
   task automatic arm_and_cancel();
      int unsigned press_ticks;
      press_ticks = at_least_one(samples_now) + at_least_one(normal_now);
      repeat (press_ticks) send_tick(1'b1, slow_speed());
      repeat ($urandom_range(0, 5)) begin
         send_tick(1'b1, ($urandom_range(0, 2) == 0) ? level_speed() : slow_speed());
      end
      send_tick(1'b1, fast_speed());
      release_button();
   endtask

   // press too short to arm, any speed
   task automatic tap_button();
      int unsigned limit;
      limit = at_least_one(samples_now) + at_least_one(normal_now) - 1;
      if (limit > 12) limit = 12;
      repeat ($urandom_range(1, limit)) send_tick(1'b1, speed_type'($urandom));
      release_button();
   endtask

   // bouncing pin with a spinning motor, never arms
   task automatic button_noise();
      repeat ($urandom_range(1, 16)) send_tick(1'($urandom_range(0, 1)), fast_speed());
      release_button();
   endtask

   task automatic run_sequences(input int unsigned tick_goal);
      int unsigned start_count;
      int unsigned pick;
      start_count = ticks_sent;
      while (ticks_sent - start_count < tick_goal) begin
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on <= ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 19) == 0) wait_results();
         pick = $urandom_range(0, 9);
         if (pick < 6) arm_and_cancel();
         else if (pick < 8) tap_button();
         else button_noise();
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.raw_level   = 1'b0;
      req_ch.motor_speed = '0;
      rsp_ch.ready       = 1'b0;
      csr_write_en       = 1'b0;
      csr_index          = CSR_DEBOUNCE_SAMPLES;
      csr_write_data     = '0;
      samples_now        = DEBOUNCE_SAMPLES_RST;
      normal_now         = NORMAL_HOLD_RST;
      threshold_now      = SPEED_THRESHOLD_RST;
      repeat (8) @(posedge clock);
      reset         <= 1'b0;
      rsp_stalls_on <= 1'b1;

      // reset settings: speed extremes, a one-sample glitch, a short press
      send_tick(1'b0, speed_type'(0));
      send_tick(1'b0, SPEED_MAX);
      send_tick(1'b0, SPEED_MIN);
      send_tick(1'b1, -speed_type'(1));
      send_tick(1'b0, speed_type'(1));
      send_tick(1'b1, speed_type'(100));
      send_tick(1'b1, -speed_type'(100));
      send_tick(1'b1, speed_type'(99));
      send_tick(1'b0, SPEED_MIN);
      send_tick(1'b0, SPEED_MAX);
      send_tick(1'b0, speed_type'(101));
      run_sequences(60);

      // no debounce, arm at once, widest threshold
      wait_results();
      load_settings(0, 0, HoldTop, ThresholdTop);
      run_sequences(40);

      wait_results();
      load_settings(1, 3, 400, $urandom_range(1, 2000));
      run_sequences(40);

      // longest debounce, zero threshold so nothing arms
      wait_results();
      load_settings(255, 1, HoldTop, 0);
      tap_button();

      repeat (2) begin
         wait_results();
         load_settings($urandom_range(1, 6), $urandom_range(0, 10),
                       $urandom_range(300, HoldTop), $urandom_range(0, ThresholdTop));
         run_sequences(30);
      end

      // long hold before arming, no idling
      wait_results();
      req_gaps_on   = 1'b0;
      rsp_stalls_on <= 1'b0;
      load_settings(1, 40, HoldTop, 100);
      arm_and_cancel();

      // normal limit above emergency limit with the speed right at the threshold:
      // force arm, release, then the request must stick
      wait_results();
      req_gaps_on   = 1'b1;
      rsp_stalls_on <= 1'b1;
      load_settings(3, 4, 0, 100);
      repeat (9) send_tick(1'b1, level_speed());
      repeat (4) send_tick(1'b0, level_speed());
      repeat (40) send_tick(1'($urandom_range(0, 1)), speed_type'($urandom));

      wait_results();
      if (fail_total == 0 && results_pending == 0) begin
         $display("tb_power_button_shutdown_fsm_core: done, clean");
      end else begin
         $display("tb_power_button_shutdown_fsm_core: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #15_000_000;
      $display("tb_power_button_shutdown_fsm_core: done, errors");
      $finish;
   end

endmodule
